[design/tle_pkg.sv]
package tle_pkg;

    localparam int LINE_DEPTH  = 32;
    localparam int CMD_Q_DEPTH = 4;

    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SP    = 8'd32;
    localparam logic [7:0] CH_DEL   = 8'd127;
    localparam logic [7:0] CTRL_TOP = 8'd27;

    localparam logic [2:0] OP_RAW   = 3'd0;
    localparam logic [2:0] OP_STORE = 3'd1;
    localparam logic [2:0] OP_BS    = 3'd2;
    localparam logic [2:0] OP_DEL   = 3'd3;
    localparam logic [2:0] OP_LF    = 3'd4;
    localparam logic [2:0] OP_CR    = 3'd5;

    localparam logic REG_RAW_MODE = 1'b0;
    localparam logic REG_ECHO_ON  = 1'b1;

    typedef struct packed {
        logic [2:0] op;
        logic       echo;
        logic [7:0] data;
    } cmd_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic full;
        logic empty;
    } q_ctl_t;

endpackage

[design/tle_front.sv]
module tle_front (
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [7:0]    s_axis_tdata,   // [7:0] byte_in
    input  logic          raw_mode,
    input  logic          echo_on,
    input  logic          q_full,
    output logic          push,
    output tle_pkg::cmd_t cmd
);
    import tle_pkg::*;

    logic keep;

    assign s_axis_tready = !q_full;

    always_comb
    begin
        cmd.echo = echo_on;
        cmd.data = s_axis_tdata;
        cmd.op   = OP_RAW;
        keep     = 1'b1;
        if (raw_mode)
        begin
            cmd.op = OP_RAW;
        end
        else if (s_axis_tdata == CH_DEL)
        begin
            cmd.op = OP_DEL;
        end
        else if (s_axis_tdata > CTRL_TOP)
        begin
            cmd.op = OP_STORE;
        end
        else
        begin
            case (s_axis_tdata)
                CH_BS:
                begin
                    cmd.op = OP_BS;
                end
                CH_LF:
                begin
                    // silent LF changes nothing
                    cmd.op = OP_LF;
                    keep   = echo_on;
                end
                CH_CR:
                begin
                    cmd.op = OP_CR;
                end
                default:
                begin
                    keep = 1'b0;
                end
            endcase
        end
    end

    assign push = s_axis_tvalid && s_axis_tready && keep;

endmodule

[design/tle_cmd_queue.sv]
module tle_cmd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tle_pkg::cmd_t push_cmd,
    input  logic          pop,
    output tle_pkg::cmd_t head_cmd,
    output logic          full,
    output logic          empty
);
    import tle_pkg::*;

    localparam int PW = $clog2(CMD_Q_DEPTH);

    cmd_t          entry_reg [CMD_Q_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW:0]   count_reg;

    assign full     = (count_reg == (PW+1)'(CMD_Q_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_cmd = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[design/tle_back.sv]
module tle_back #(
    parameter int BUF_DEPTH = tle_pkg::LINE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  tle_pkg::cmd_t q_cmd,
    output logic          pop,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [7:0]    m_axis_tdata,   // [7:0] out_byte
    output logic          m_axis_tuser,   // [0] out_kind
    output logic          m_axis_tlast
);
    import tle_pkg::*;

    localparam int IW = $clog2(BUF_DEPTH);
    localparam logic [IW-1:0] TOP_IDX = IW'(BUF_DEPTH - 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_EMIT   = 2'd1;
    localparam logic [1:0] ST_FL_RD  = 2'd2;
    localparam logic [1:0] ST_FL_OUT = 2'd3;

    function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] i);
        return (i == TOP_IDX) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] i);
        return (i == '0) ? TOP_IDX : i - 1'b1;
    endfunction

    // number of echo/raw words before any line delivery
    function automatic logic [1:0] fixed_count(input cmd_t c);
        logic [1:0] n;
        case (c.op)
            OP_RAW:   n = c.echo ? 2'd2 : 2'd1;
            OP_STORE: n = c.echo ? 2'd1 : 2'd0;
            OP_BS:    n = c.echo ? 2'd3 : 2'd0;
            OP_DEL:   n = 2'd3;
            OP_LF:    n = c.echo ? 2'd1 : 2'd0;
            OP_CR:    n = c.echo ? 2'd2 : 2'd0;
            default:  n = 2'd0;
        endcase
        return n;
    endfunction

    // {kind, byte} of fixed word number step
    function automatic logic [8:0] fixed_item(input cmd_t c, input logic [1:0] step);
        logic [8:0] r;
        case (c.op)
            OP_RAW:        r = (c.echo && step == 2'd0) ? {1'b0, c.data} : {1'b1, c.data};
            OP_STORE:      r = {1'b0, c.data};
            OP_BS, OP_DEL: r = (step == 2'd1) ? {1'b0, CH_SP} : {1'b0, CH_BS};
            OP_LF:         r = {1'b0, CH_LF};
            OP_CR:         r = (step == 2'd0) ? {1'b0, CH_CR} : {1'b0, CH_LF};
            default:       r = {1'b0, c.data};
        endcase
        return r;
    endfunction

    logic [7:0]    line_mem [BUF_DEPTH];
    logic [7:0]    mem_q;

    logic [1:0]    state_reg, state_next;
    logic [1:0]    step_reg, step_next;
    cmd_t          cmd_reg, cmd_next;
    logic [IW-1:0] rd_idx_reg, rd_idx_next;
    logic [IW-1:0] wr_idx_reg, wr_idx_next;
    logic          out_valid_reg, out_valid_next;
    logic          out_kind_reg;
    logic [7:0]    out_byte_reg;
    logic          out_last_reg;

    logic          load;
    logic          ld_kind;
    logic [7:0]    ld_byte;
    logic          ld_last;
    logic          mem_we;
    logic          out_free;
    logic          nonempty;
    logic          last_step;
    logic          flush;
    logic [1:0]    cnt;

    assign out_free = !out_valid_reg || m_axis_tready;
    assign nonempty = (rd_idx_reg != wr_idx_reg);
    assign cnt      = fixed_count(cmd_reg);

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        cmd_next    = cmd_reg;
        rd_idx_next = rd_idx_reg;
        wr_idx_next = wr_idx_reg;
        pop         = 1'b0;
        load        = 1'b0;
        ld_kind     = 1'b0;
        ld_byte     = mem_q;
        ld_last     = 1'b0;
        mem_we      = 1'b0;
        last_step   = (step_reg == cnt - 2'd1);
        flush       = (cmd_reg.op == OP_CR) && nonempty;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    pop       = 1'b1;
                    cmd_next  = q_cmd;
                    step_next = 2'd0;
                    case (q_cmd.op)
                        OP_STORE:
                        begin
                            mem_we      = 1'b1;
                            wr_idx_next = idx_inc(wr_idx_reg);
                            // full ring drops the oldest byte
                            if (idx_inc(wr_idx_reg) == rd_idx_reg)
                            begin
                                rd_idx_next = idx_inc(rd_idx_reg);
                            end
                        end
                        OP_BS, OP_DEL:
                        begin
                            if (nonempty)
                            begin
                                wr_idx_next = idx_dec(wr_idx_reg);
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    if (fixed_count(q_cmd) != 2'd0)
                    begin
                        state_next = ST_EMIT;
                    end
                    else if (q_cmd.op == OP_CR && nonempty)
                    begin
                        state_next = ST_FL_RD;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    load               = 1'b1;
                    {ld_kind, ld_byte} = fixed_item(cmd_reg, step_reg);
                    ld_last            = last_step && !flush;
                    step_next          = step_reg + 1'b1;
                    if (last_step)
                    begin
                        state_next = flush ? ST_FL_RD : ST_IDLE;
                    end
                end
            end
            ST_FL_RD:
            begin
                // mem_q catches the entry at rd_idx_reg
                state_next = ST_FL_OUT;
            end
            ST_FL_OUT:
            begin
                if (out_free)
                begin
                    load        = 1'b1;
                    ld_kind     = 1'b1;
                    ld_byte     = mem_q;
                    ld_last     = (idx_inc(rd_idx_reg) == wr_idx_reg);
                    rd_idx_next = idx_inc(rd_idx_reg);
                    state_next  = ld_last ? ST_IDLE : ST_FL_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            rd_idx_reg    <= '0;
            wr_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            rd_idx_reg    <= rd_idx_next;
            wr_idx_reg    <= wr_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        if (load)
        begin
            out_kind_reg <= ld_kind;
            out_byte_reg <= ld_byte;
            out_last_reg <= ld_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_mem[wr_idx_reg] <= q_cmd.data;
        end
        mem_q <= line_mem[rd_idx_reg];
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

[design/tty_line_editor_core.sv]
// Keyboard line editor. Each input word is one received byte; the front end
// classifies it and queues a command (up to four deep), and the back end runs
// it against the ring line buffer and emits words through an output register
// (tuser 0 = echo toward terminal, 1 = delivered line byte; tlast on the final
// word an input byte causes). A byte that yields fixed words (raw, echo,
// rub-out, CR LF) is popped in the idle state and sent from the emit state;
// a carriage return then walks the buffered bytes (31 in a full line), a read
// and an output state per byte, set by the registered read of the line-store
// memory. Ignored control codes and silent line feeds never reach the back
// end. No clearing pass follows reset. Registers: 0x0 raw_mode, 0x4 echo_on.
module tty_line_editor_core #(
    parameter int BUF_DEPTH = tle_pkg::LINE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tuser,   // [0] out_kind
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tle_pkg::*;

    logic   raw_mode_reg;
    logic   echo_on_reg;
    logic   cfg_wr;
    q_ctl_t qc;
    cmd_t   push_cmd;
    cmd_t   head_cmd;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_ECHO_ON) ? {31'd0, echo_on_reg}
                                               : {31'd0, raw_mode_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_mode_reg <= 1'b0;
            echo_on_reg  <= 1'b1;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_RAW_MODE)
            begin
                raw_mode_reg <= pwdata[0];
            end
            else
            begin
                echo_on_reg <= pwdata[0];
            end
        end
    end

    tle_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .raw_mode      (raw_mode_reg),
        .echo_on       (echo_on_reg),
        .q_full        (qc.full),
        .push          (qc.push),
        .cmd           (push_cmd)
    );

    tle_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (qc.push),
        .push_cmd (push_cmd),
        .pop      (qc.pop),
        .head_cmd (head_cmd),
        .full     (qc.full),
        .empty    (qc.empty)
    );

    tle_back #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (qc.empty),
        .q_cmd         (head_cmd),
        .pop           (qc.pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        qc.push |-> !qc.full)
        else $error("command pushed into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        qc.pop |-> !qc.empty)
        else $error("command popped from empty queue");

    a_raw_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast && raw_mode_reg) |-> m_axis_tuser)
        else $error("raw byte final word not marked as delivered");
`endif

endmodule
